/* rtl/aes_pkg.sv */
// AES-128 package: S-box tables, round constants and GF(2^8) helpers.
// Standalone; used by the cipher core and key schedule.
package aes_pkg;

   localparam int RoundKeyWords = 44;
   localparam int RoundKeys = RoundKeyWords / 4;
   localparam int RkAddrW = $clog2(RoundKeys);
   localparam int NumRounds = 10;

   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_DECRYPT  = 2'd2;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;
   typedef logic [RkAddrW-1:0] rk_addr_type;

   function automatic byte_type sbox_fwd(input byte_type b);
      byte_type t [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[b];
   endfunction

   function automatic byte_type sbox_inv(input byte_type b);
      byte_type t [256] = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[b];
   endfunction

   function automatic byte_type rcon(input logic [3:0] idx);
      byte_type r;
      case (idx)
         4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
         4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
         4'd8: r = 8'h1b; 4'd9: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic byte_type xtime(input byte_type b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Multiply by a 4-bit constant in GF(2^8).
   function automatic byte_type gmul(input byte_type a, input logic [3:0] k);
      byte_type acc;
      byte_type x;
      acc = '0;
      x = a;
      for (int i = 0; i < 4; i++) begin
         if (k[i]) acc = acc ^ x;
         x = xtime(x);
      end
      return acc;
   endfunction

   // Byte i of the block (byte 0 most significant) is row i%4 of column i/4.
   function automatic block_type mix_cols(input block_type s, input logic inv);
      block_type o;
      logic [3:0] m [4];
      byte_type a [4];
      if (inv) m = '{4'he, 4'hb, 4'hd, 4'h9};
      else m = '{4'h2, 4'h3, 4'h1, 4'h1};
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) a[r] = s[127 - 8*(4*c + r) -: 8];
         for (int r = 0; r < 4; r++)
            o[127 - 8*(4*c + r) -: 8] = gmul(a[0], m[(4 - r) & 3]) ^ gmul(a[1], m[(5 - r) & 3])
               ^ gmul(a[2], m[(6 - r) & 3]) ^ gmul(a[3], m[(7 - r) & 3]);
      end
      return o;
   endfunction

   function automatic block_type shift_rows(input block_type s, input logic inv);
      block_type o;
      int d;
      d = inv ? 3 : 1;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            o[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*((c + d*r) & 3)) -: 8];
      return o;
   endfunction

   function automatic block_type sub_bytes(input block_type s, input logic inv);
      block_type o;
      for (int i = 0; i < 16; i++)
         o[8*i +: 8] = inv ? sbox_inv(s[8*i +: 8]) : sbox_fwd(s[8*i +: 8]);
      return o;
   endfunction

endpackage

/* rtl/aes_if.sv */
// Valid/ready channel interfaces for the AES block: data words and register writes.
// Depends on nothing.
interface aes_data_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic        last_block;
   modport source (output valid, block_high, block_low, last_block, input ready);
   modport sink (input valid, block_high, block_low, last_block, output ready);
endinterface

interface aes_result_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   logic        last_out;
   modport source (output valid, result_high, result_low, last_out, input ready);
   modport sink (input valid, result_high, result_low, last_out, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/aes128_block_cipher.sv */
// AES-128 ECB engine top level: key schedule, shared round unit and result register.
// Depends on aes_pkg and the channel interfaces in aes_if.sv.
//
// Usage:
//  - csr_: register writes. Index 0 key_high, 1 key_low, 2 decrypt_mode.
//    A key write starts expansion into eleven 128-bit round keys, one round
//    key a cycle; no word is accepted on csr_ or req_ meanwhile.
//    Configuration takes priority over a data word offered in the same cycle.
//  - req_: one 128-bit block per word plus a last flag.
//  - rsp_: one 128-bit result per word, last flag copied through.
// Timing: the accepted block runs through the shared round unit (the
// initial key add plus ten rounds, one step a cycle); the result of the
// last step is loaded into the output register. One block is in the
// round unit at a time; the next word is accepted the cycle after the
// last step when the receiver keeps up. The round unit and the round-key
// memory's single read port set this pace.
// Reset clears control state; round keys stay undefined until a key is written.
// When the receiver stalls the result holds in the output register; the next
// block finishes and parks in the round unit, and no new word is accepted
// until the output register frees up.
module aes128_block_cipher (
   input logic          clock,
   input logic          reset,
   aes_data_if.sink     req_ch,
   aes_result_if.source rsp_ch,
   aes_csr_if.sink      csr_ch
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;
   localparam logic [1:0] ST_KEY  = 2'd3;
   localparam aes_pkg::rk_addr_type LAST_STEP = aes_pkg::rk_addr_type'(aes_pkg::NumRounds);
   localparam aes_pkg::rk_addr_type ONE_STEP  = aes_pkg::rk_addr_type'(1);

   logic [1:0]           state_ff, state_in;
   aes_pkg::rk_addr_type step_ff, step_in;
   aes_pkg::rk_addr_type kround_ff;
   logic [63:0]          key_high_ff, key_low_ff;
   logic                 dec_ff;
   aes_pkg::block_type   kcur_ff;
   aes_pkg::block_type   knext;
   aes_pkg::block_type   new_key;
   aes_pkg::block_type   st_ff, st_in;
   logic                 last_ff;
   aes_pkg::block_type   res_ff;
   aes_pkg::block_type   res_data;
   logic                 res_last_ff;
   logic                 res_valid_ff;
   logic                 res_load;

   logic csr_fire, req_fire, rsp_fire, key_write;

   // Round-key memory: one round key per entry, one write and one registered read port.
   aes_pkg::block_type   rk_mem [aes_pkg::RoundKeys];
   aes_pkg::block_type   rkey_ff;
   aes_pkg::rk_addr_type rd_addr, wr_addr;
   logic                 rk_we;
   aes_pkg::block_type   rk_wdata;

   assign csr_ch.ready = (state_ff == ST_IDLE);
   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_ch.valid;
   assign rsp_ch.valid = res_valid_ff;
   assign rsp_ch.result_high = res_ff[127:64];
   assign rsp_ch.result_low = res_ff[63:0];
   assign rsp_ch.last_out = res_last_ff;

   assign csr_fire = csr_ch.valid && csr_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign key_write = csr_fire && (csr_ch.index == aes_pkg::CSR_KEY_HIGH ||
                                   csr_ch.index == aes_pkg::CSR_KEY_LOW);

   // Full key as it stands after the pending key write.
   always_comb begin
      new_key = {key_high_ff, key_low_ff};
      if (csr_ch.index == aes_pkg::CSR_KEY_HIGH) new_key[127:64] = csr_ch.data;
      else new_key[63:0] = csr_ch.data;
   end

   // Next round key from the previous one: rotate, substitute, add rcon, chain.
   always_comb begin
      logic [31:0] t;
      t = kcur_ff[31:0];
      t = {aes_pkg::sbox_fwd(t[23:16]), aes_pkg::sbox_fwd(t[15:8]),
           aes_pkg::sbox_fwd(t[7:0]), aes_pkg::sbox_fwd(t[31:24])};
      t[31:24] = t[31:24] ^ aes_pkg::rcon(kround_ff - ONE_STEP);
      knext[127:96] = kcur_ff[127:96] ^ t;
      knext[95:64] = kcur_ff[95:64] ^ knext[127:96];
      knext[63:32] = kcur_ff[63:32] ^ knext[95:64];
      knext[31:0] = kcur_ff[31:0] ^ knext[63:32];
   end

   // Write the raw key at the write edge, then one expanded key a cycle.
   always_comb begin
      rk_we = key_write || (state_ff == ST_KEY);
      wr_addr = key_write ? '0 : kround_ff;
      rk_wdata = key_write ? new_key : knext;
   end

   // Fetch the key for the step that runs in the next cycle.
   always_comb begin
      rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: rd_addr = dec_ff ? LAST_STEP : '0;
         ST_RUN: begin
            if (step_ff != LAST_STEP)
               rd_addr = dec_ff ? (LAST_STEP - step_ff - ONE_STEP) : (step_ff + ONE_STEP);
         end
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rk_we) rk_mem[wr_addr] <= rk_wdata;
      rkey_ff <= rk_mem[rd_addr];
   end

   // Round unit: step 0 is the initial key add, steps 1..10 are rounds, step 10 without MixColumns.
   always_comb begin
      aes_pkg::block_type s;
      state_in = state_ff;
      step_in = step_ff;
      st_in = st_ff;
      res_load = 1'b0;
      res_data = st_ff;
      if (step_ff == '0) begin
         s = st_ff ^ rkey_ff;
      end else if (!dec_ff) begin
         s = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_ff, 1'b0), 1'b0);
         if (step_ff != LAST_STEP) s = aes_pkg::mix_cols(s, 1'b0);
         s = s ^ rkey_ff;
      end else begin
         s = aes_pkg::sub_bytes(aes_pkg::shift_rows(st_ff, 1'b1), 1'b1) ^ rkey_ff;
         if (step_ff != LAST_STEP) s = aes_pkg::mix_cols(s, 1'b1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               step_in = '0;
               st_in = {req_ch.block_high, req_ch.block_low};
            end else if (key_write) begin
               state_in = ST_KEY;
            end
         end
         ST_RUN: begin
            st_in = s;
            step_in = step_ff + ONE_STEP;
            if (step_ff == LAST_STEP) begin
               step_in = '0;
               // Hand over to the output register, or park until it frees up.
               if (!res_valid_ff || rsp_ch.ready) begin
                  res_load = 1'b1;
                  res_data = s;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!res_valid_ff || rsp_ch.ready) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_KEY: begin
            if (kround_ff == LAST_STEP) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         key_high_ff <= '0;
         key_low_ff <= '0;
         dec_ff <= 1'b0;
         kround_ff <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         if (res_load) res_valid_ff <= 1'b1;
         else if (rsp_fire) res_valid_ff <= 1'b0;
         if (csr_fire) begin
            unique case (csr_ch.index)
               aes_pkg::CSR_KEY_HIGH: key_high_ff <= csr_ch.data;
               aes_pkg::CSR_KEY_LOW: key_low_ff <= csr_ch.data;
               aes_pkg::CSR_DECRYPT: dec_ff <= csr_ch.data[0];
               default: ;
            endcase
         end
         if (key_write) kround_ff <= ONE_STEP;
         else if (state_ff == ST_KEY) kround_ff <= kround_ff + ONE_STEP;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (req_fire) last_ff <= req_ch.last_block;
      if (key_write) kcur_ff <= new_key;
      else if (state_ff == ST_KEY) kcur_ff <= knext;
      if (res_load) begin
         res_ff <= res_data;
         res_last_ff <= last_ff;
      end
   end
endmodule

/* rtl/aes_checker.sv */
// Port-level checker for the AES block, bound to the top level.
// Its ports are plain signals; the bind below connects them to the top level's channel interfaces.
module aes_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_valid,
   input logic csr_ready
);
   // Never take a data word and a register write together.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && csr_valid && csr_ready))
      else $error("data word and register write accepted together");
   // A result follows each accepted word on the output.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> ##12 rsp_valid) else $error("result latency");
   // Result stays until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
   // Hold off new words while the round unit runs.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready [*11]) else $error("word taken while busy");
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .csr_valid(csr_ch.valid), .csr_ready(csr_ch.ready)
);
